>>> rtl/bst_pkg.sv
// Package for the breakpoint slot table: sizes, command and status codes,
// and the item type passed from the front stage through the queue to the back unit.
// No dependencies.
`default_nettype none
package bst_pkg;

   localparam int SLOT_COUNT    = 32;
   localparam int ADDRESS_WIDTH = 32;
   localparam int SLOT_W        = $clog2(SLOT_COUNT);
   localparam int CNT_W         = $clog2(SLOT_COUNT + 1);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_CHECK  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_FULL       = 2'd1,
      STATUS_NOT_ACTIVE = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      OP_ADD    = 4'b0001,
      OP_DELETE = 4'b0010,
      OP_CHECK  = 4'b0100,
      OP_NOP    = 4'b1000
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_SELECT = 2'b10
   } back_state_type;

   typedef struct packed {
      op_type                   op;
      logic [ADDRESS_WIDTH-1:0] address;
      logic [SLOT_W-1:0]        slot_number;
   } item_type;

endpackage
`default_nettype wire

>>> rtl/bst_front.sv
// Front stage: registers an incoming transaction and decodes its command.
// Depends on bst_pkg.
`default_nettype none
module bst_front import bst_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [1:0]               req_cmd,
   input  wire logic [ADDRESS_WIDTH-1:0] req_address,
   input  wire logic [SLOT_W-1:0]        req_slot_number,
   output logic                          push_valid,
   input  wire logic                     queue_full,
   output item_type                      push_item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;
   op_type   op_dec;

   always_comb begin
      case (cmd_type'(req_cmd))
         CMD_ADD:    op_dec = OP_ADD;
         CMD_DELETE: op_dec = OP_DELETE;
         CMD_CHECK:  op_dec = OP_CHECK;
         default:    op_dec = OP_NOP;
      endcase
   end

   assign req_stall = valid_ff & queue_full;
   assign accept    = req_valid & ~req_stall;
   assign valid_in  = accept | (valid_ff & queue_full);

   always_comb begin
      item_in = item_ff;
      if (accept) begin
         item_in.op          = op_dec;
         item_in.address     = req_address;
         item_in.slot_number = req_slot_number;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign push_valid = valid_ff;
   assign push_item  = item_ff;

endmodule
`default_nettype wire

>>> rtl/bst_queue.sv
// Short queue between the front stage and the back unit.
// Depends on bst_pkg.
`default_nettype none
module bst_queue import bst_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push_valid,
   input  wire item_type push_item,
   output logic          full,
   output logic          pop_valid,
   input  wire logic     pop,
   output item_type      pop_item
);

   item_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid & ~full;
   assign do_pop    = pop & pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push & ~do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

>>> rtl/bst_back.sv
// Back unit: slot state, free stack, per-slot comparators, recency matrix
// and the result register. Depends on bst_pkg.
`default_nettype none
module bst_back import bst_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 queue_valid,
   input  wire item_type             queue_item,
   output logic                      queue_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [1:0]                rsp_status,
   output logic                      rsp_hit,
   output logic [SLOT_W-1:0]         rsp_result_slot
);

   back_state_type           state_ff, state_in;
   logic [SLOT_COUNT-1:0]    active_ff, active_in;
   logic [ADDRESS_WIDTH-1:0] addr_ff [SLOT_COUNT];
   // newer_ff[i][j]: slot j was added after slot i
   logic [SLOT_COUNT-1:0]    newer_ff [SLOT_COUNT];
   logic [SLOT_W-1:0]        stack_ff [SLOT_COUNT];
   logic [CNT_W-1:0]         free_ff, free_in, free_dec;
   logic [SLOT_COUNT-1:0]    match_ff, match_in, winner;
   logic [SLOT_W-1:0]        top_slot, winner_slot;
   logic                     out_free, do_add, do_del, take_chk, out_load;
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic                     rsp_hit_ff, rsp_hit_in;
   logic [SLOT_W-1:0]        rsp_slot_ff, rsp_slot_in;

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign queue_pop = (state_ff == ST_IDLE) & queue_valid & out_free;
   assign free_dec  = free_ff - CNT_W'(1);
   assign top_slot  = stack_ff[free_dec[SLOT_W-1:0]];
   assign do_add    = queue_pop & (queue_item.op == OP_ADD) & (free_ff != '0);
   assign do_del    = queue_pop & (queue_item.op == OP_DELETE)
                      & active_ff[queue_item.slot_number];
   assign take_chk  = queue_pop & (queue_item.op == OP_CHECK);

   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         match_in[i] = active_ff[i] & (addr_ff[i] == queue_item.address);
         winner[i]   = match_ff[i] & ~|(match_ff & newer_ff[i]);
      end
   end

   always_comb begin
      winner_slot = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (winner[i]) begin
            winner_slot = winner_slot | SLOT_W'(i);
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      active_in = active_ff;
      free_in   = free_ff;
      if (do_add) begin
         active_in[top_slot] = 1'b1;
         free_in             = free_dec;
      end
      if (do_del) begin
         active_in[queue_item.slot_number] = 1'b0;
         free_in                           = free_ff + CNT_W'(1);
      end
      case (state_ff)
         ST_IDLE: begin
            if (take_chk) begin
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_load      = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_slot_in   = rsp_slot_ff;
      if (state_ff == ST_SELECT) begin
         out_load      = out_free;
         rsp_status_in = STATUS_OK;
         rsp_hit_in    = |match_ff;
         rsp_slot_in   = winner_slot;
      end else if (queue_pop & ~take_chk) begin
         out_load      = 1'b1;
         rsp_status_in = STATUS_OK;
         rsp_hit_in    = 1'b0;
         rsp_slot_in   = '0;
         case (queue_item.op)
            OP_ADD: begin
               if (free_ff == '0) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  rsp_slot_in = top_slot;
               end
            end
            OP_DELETE: begin
               if (~active_ff[queue_item.slot_number]) begin
                  rsp_status_in = STATUS_NOT_ACTIVE;
               end
            end
            default: rsp_status_in = STATUS_OK;
         endcase
      end
      rsp_valid_in = out_load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         free_ff      <= CNT_W'(SLOT_COUNT);
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            stack_ff[i] <= SLOT_W'(SLOT_COUNT - 1 - i);
         end
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
         if (do_del) begin
            stack_ff[free_ff[SLOT_W-1:0]] <= queue_item.slot_number;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_add) begin
         addr_ff[top_slot] <= queue_item.address;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (SLOT_W'(i) == top_slot) begin
               newer_ff[i] <= '0;
            end else begin
               newer_ff[i][top_slot] <= 1'b1;
            end
         end
      end
      if (take_chk) begin
         match_ff <= match_in;
      end
      if (out_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_hit_ff    <= rsp_hit_in;
         rsp_slot_ff   <= rsp_slot_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_result_slot = rsp_slot_ff;

`ifndef SYNTH
   a_free_matches_active: assert property (@(posedge clock) disable iff (reset)
      ($countones(active_ff) + int'(free_ff)) == SLOT_COUNT)
      else $error("free count out of step with active slots");

   a_single_winner: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SELECT) |-> ($onehot(winner) || (match_ff == '0)))
      else $error("recency select found no unique winner");

   a_add_activates: assert property (@(posedge clock) disable iff (reset)
      do_add |=> active_ff[$past(top_slot)])
      else $error("added slot not active");
`endif

endmodule
`default_nettype wire

>>> rtl/breakpoint_slot_table.sv
// Breakpoint slot table top level: front stage, queue and back unit.
// Throughput: one add, delete or no-op per cycle while the result output is not stalled;
// a check is not followed by the next item until its compare and select steps are done.
// The back unit's recency select sets the check rate; the queue holds two transactions.
// Reset is synchronous: no slot active, free stack reloaded to yield 0,1,2,...; no clearing pass.
// Depends on bst_pkg, bst_front, bst_queue, bst_back.
`default_nettype none
module breakpoint_slot_table import bst_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [1:0]               req_cmd,
   input  wire logic [ADDRESS_WIDTH-1:0] req_address,
   input  wire logic [SLOT_W-1:0]        req_slot_number,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_hit,
   output logic [SLOT_W-1:0]             rsp_result_slot
);

   logic     push_valid, queue_full, queue_valid, queue_pop;
   item_type push_item, queue_item;

   bst_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_address     (req_address),
      .req_slot_number (req_slot_number),
      .push_valid      (push_valid),
      .queue_full      (queue_full),
      .push_item       (push_item)
   );

   bst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop_valid  (queue_valid),
      .pop        (queue_pop),
      .pop_item   (queue_item)
   );

   bst_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_valid     (queue_valid),
      .queue_item      (queue_item),
      .queue_pop       (queue_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_hit         (rsp_hit),
      .rsp_result_slot (rsp_result_slot)
   );

endmodule
`default_nettype wire

>>> dv/tb.sv
// Testbench for breakpoint_slot_table: directed table, then random add/delete/check traffic.
// Results come from an in-bench slot table model or a directed row; compared in order.
// Depends on bst_pkg and breakpoint_slot_table.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bst_pkg::*;

   localparam int RANDOM_ITEMS   = 1930;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int REPORT_LIMIT   = 10;
   localparam int POOL_SIZE      = 8;

   typedef enum int {FILL_UP, DRAIN_DOWN, MIXED} mix_mode_type;

   typedef struct packed {
      status_type        status;
      logic              hit;
      logic [SLOT_W-1:0] slot;
   } bp_result_type;

   typedef struct packed {
      cmd_type                  op;
      logic [ADDRESS_WIDTH-1:0] pc;
      logic [SLOT_W-1:0]        num;
      logic                     typed;
      status_type               status;
      logic                     hit;
      logic [SLOT_W-1:0]        slot;
   } stim_row_type;

   logic                     clock           = 1'b0;
   logic                     reset           = 1'b1;
   logic                     req_valid       = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_cmd         = CMD_NONE;
   logic [ADDRESS_WIDTH-1:0] req_address     = '0;
   logic [SLOT_W-1:0]        req_slot_number = '0;
   logic                     rsp_valid;
   logic                     rsp_stall       = 1'b0;
   logic [1:0]               rsp_status;
   logic                     rsp_hit;
   logic [SLOT_W-1:0]        rsp_result_slot;

   // slot table model
   bit                       armed [SLOT_COUNT];
   logic [ADDRESS_WIDTH-1:0] bp_addr [SLOT_COUNT];
   logic [SLOT_W-1:0]        newest_first [$];
   logic [SLOT_W-1:0]        free_slots [$];

   bp_result_type            pending_results [$];
   logic [ADDRESS_WIDTH-1:0] addr_pool [POOL_SIZE];
   stim_row_type             directed_rows [23];

   int mismatches, n_compared, idle_cycles;
   int n_add, n_full, n_del, n_not_active, n_check, n_hit, n_noop;
   int sender_calm, stall_left, calm_left;

   breakpoint_slot_table uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_address     (req_address),
      .req_slot_number (req_slot_number),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_hit         (rsp_hit),
      .rsp_result_slot (rsp_result_slot)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic bp_result_type table_apply(cmd_type op, logic [ADDRESS_WIDTH-1:0] pc,
                                                 logic [SLOT_W-1:0] num);
      bp_result_type     r;
      logic [SLOT_W-1:0] s;
      int                pos;
      r   = '{STATUS_OK, 1'b0, '0};
      pos = -1;
      case (op)
         CMD_ADD: begin
            if (free_slots.size() == 0) begin
               r.status = STATUS_FULL;
            end else begin
               s          = free_slots.pop_front();
               armed[s]   = 1'b1;
               bp_addr[s] = pc;
               newest_first.push_front(s);
               r.slot     = s;
            end
         end
         CMD_DELETE: begin
            if (!armed[num]) begin
               r.status = STATUS_NOT_ACTIVE;
            end else begin
               armed[num] = 1'b0;
               foreach (newest_first[i])
                  if (pos < 0 && newest_first[i] == num) pos = i;
               if (pos >= 0) newest_first.delete(pos);
               free_slots.push_front(num);
            end
         end
         CMD_CHECK: begin
            foreach (newest_first[i]) begin
               if (!r.hit && bp_addr[newest_first[i]] == pc) begin
                  r.hit  = 1'b1;
                  r.slot = newest_first[i];
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (sender_calm > 0) begin
         sender_calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) sender_calm = $urandom_range(30, 100);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_item(cmd_type op, logic [ADDRESS_WIDTH-1:0] pc, logic [SLOT_W-1:0] num,
                            bit typed, bp_result_type typed_r);
      int            gap;
      bp_result_type r;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_cmd         <= op;
      req_address     <= pc;
      req_slot_number <= num;
      do @(posedge clock); while (req_stall);
      r = table_apply(op, pc, num);
      case (op)
         CMD_ADD:    begin n_add++;   if (r.status == STATUS_FULL) n_full++; end
         CMD_DELETE: begin n_del++;   if (r.status == STATUS_NOT_ACTIVE) n_not_active++; end
         CMD_CHECK:  begin n_check++; if (r.hit) n_hit++; end
         default:    n_noop++;
      endcase
      pending_results.push_back(typed ? typed_r : r);
   endtask

   task automatic drain_pipeline();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // result side back-pressure
   always @(negedge clock) begin
      int r;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (calm_left > 0) begin
         calm_left--;
         rsp_stall <= 1'b0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 4) calm_left = $urandom_range(50, 200);
         else if (r < 40) stall_left = $urandom_range(0, 2);
         else if (r < 43) stall_left = $urandom_range(10, 40);
         rsp_stall <= (r >= 4 && r < 43);
      end
   end

   always @(posedge clock) begin
      bp_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: unexpected result status %0d hit %0d slot %0d",
                        $time, rsp_status, rsp_hit, rsp_result_slot);
         end else begin
            want = pending_results.pop_front();
            n_compared++;
            if (rsp_status !== want.status || rsp_hit !== want.hit
                || rsp_result_slot !== want.slot) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: result mismatch: status %0d/%0d hit %0d/%0d slot %0d/%0d (exp/act)",
                           $time, want.status, rsp_status, want.hit, rsp_hit,
                           want.slot, rsp_result_slot);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                  idle_cycles, pending_results.size());
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles++;
      end
   end

   initial begin
      int                       n_done, mode_left, r, add_pct, del_pct;
      bit                       paused;
      mix_mode_type             mode;
      cmd_type                  op;
      logic [ADDRESS_WIDTH-1:0] pc;
      logic [SLOT_W-1:0]        num;
      bp_result_type            typed_r;

      foreach (addr_pool[i]) addr_pool[i] = $urandom;
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (int i = 0; i < SLOT_COUNT; i++) free_slots.push_back(i[SLOT_W-1:0]);

      directed_rows = '{
         '{CMD_CHECK,  32'h0000_0000, 5'd31, 1'b1, STATUS_OK,         1'b0, 5'd0},
         '{CMD_DELETE, 32'hFFFF_FFFF, 5'd0,  1'b1, STATUS_NOT_ACTIVE, 1'b0, 5'd0},
         '{CMD_DELETE, 32'h0000_0000, 5'd31, 1'b1, STATUS_NOT_ACTIVE, 1'b0, 5'd0},
         '{CMD_ADD,    32'h0000_0000, 5'd31, 1'b1, STATUS_OK,         1'b0, 5'd0},
         '{CMD_ADD,    32'hFFFF_FFFF, 5'd0,  1'b1, STATUS_OK,         1'b0, 5'd1},
         '{CMD_ADD,    32'h0000_1000, 5'd7,  1'b1, STATUS_OK,         1'b0, 5'd2},
         '{CMD_ADD,    32'h0000_1000, 5'd24, 1'b1, STATUS_OK,         1'b0, 5'd3},
         '{CMD_CHECK,  32'h0000_1000, 5'd0,  1'b0, STATUS_OK,         1'b0, 5'd0},
         '{CMD_CHECK,  32'hFFFF_FFFF, 5'd0,  1'b0, STATUS_OK,         1'b0, 5'd0},
         '{CMD_CHECK,  32'h0000_0000, 5'd0,  1'b0, STATUS_OK,         1'b0, 5'd0},
         '{CMD_CHECK,  32'hFFFF_FFFE, 5'd31, 1'b0, STATUS_OK,         1'b0, 5'd0},
         '{CMD_NONE,   32'h0000_1000, 5'd31, 1'b1, STATUS_OK,         1'b0, 5'd0},
         '{CMD_DELETE, 32'h0000_0000, 5'd3,  1'b0, STATUS_OK,         1'b0, 5'd0},
         '{CMD_CHECK,  32'h0000_1000, 5'd0,  1'b0, STATUS_OK,         1'b0, 5'd0},
         '{CMD_DELETE, 32'h0000_0000, 5'd3,  1'b1, STATUS_NOT_ACTIVE, 1'b0, 5'd0},
         '{CMD_ADD,    32'h0000_1000, 5'd0,  1'b0, STATUS_OK,         1'b0, 5'd0},
         '{CMD_CHECK,  32'h0000_1000, 5'd0,  1'b0, STATUS_OK,         1'b0, 5'd0},
         '{CMD_DELETE, 32'h0000_0000, 5'd2,  1'b0, STATUS_OK,         1'b0, 5'd0},
         '{CMD_DELETE, 32'h0000_0000, 5'd0,  1'b0, STATUS_OK,         1'b0, 5'd0},
         '{CMD_CHECK,  32'h0000_0000, 5'd0,  1'b0, STATUS_OK,         1'b0, 5'd0},
         '{CMD_ADD,    32'h8000_0000, 5'd0,  1'b0, STATUS_OK,         1'b0, 5'd0},
         '{CMD_CHECK,  32'h8000_0000, 5'd0,  1'b0, STATUS_OK,         1'b0, 5'd0},
         '{CMD_NONE,   32'hFFFF_FFFF, 5'd0,  1'b1, STATUS_OK,         1'b0, 5'd0}
      };

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         typed_r = '{directed_rows[i].status, directed_rows[i].hit, directed_rows[i].slot};
         send_item(directed_rows[i].op, directed_rows[i].pc, directed_rows[i].num,
                   directed_rows[i].typed, typed_r);
      end
      drain_pipeline();

      // fill first so the full-table case comes early
      mode      = FILL_UP;
      mode_left = 120;
      n_done    = 0;
      paused    = 1'b0;
      typed_r   = '{STATUS_OK, 1'b0, '0};
      while (n_done < RANDOM_ITEMS) begin
         if (mode_left == 0) begin
            mode      = mix_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(60, 150);
         end
         mode_left--;
         case (mode)
            FILL_UP:    begin add_pct = 70; del_pct = 10; end
            DRAIN_DOWN: begin add_pct = 15; del_pct = 60; end
            default:    begin add_pct = 34; del_pct = 33; end
         endcase
         r = $urandom_range(0, 99);
         if (r < add_pct) op = CMD_ADD;
         else if (r < add_pct + del_pct) op = CMD_DELETE;
         else op = CMD_CHECK;
         if ($urandom_range(0, 99) < 3) op = CMD_NONE;

         pc  = $urandom;
         num = $urandom_range(0, SLOT_COUNT - 1);
         r   = $urandom_range(0, 99);
         if (op == CMD_ADD && r < 50) begin
            pc = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
         end else if (op == CMD_CHECK) begin
            if (r < 45 && newest_first.size() > 0)
               pc = bp_addr[newest_first[$urandom_range(0, newest_first.size() - 1)]];
            else if (r < 75)
               pc = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
         end else if (op == CMD_DELETE && r < 75 && newest_first.size() > 0) begin
            num = newest_first[$urandom_range(0, newest_first.size() - 1)];
         end

         if (!paused && n_done >= RANDOM_ITEMS / 2) begin
            paused = 1'b1;
            drain_pipeline();
         end
         send_item(op, pc, num, 1'b0, typed_r);
         n_done++;
      end
      drain_pipeline();
      repeat (8) @(posedge clock);

      $display("covered %0d adds (%0d on a full table), %0d deletes (%0d of inactive slots)",
               n_add, n_full, n_del, n_not_active);
      $display("and %0d checks (%0d hits), %0d unused commands; %0d results compared",
               n_check, n_hit, n_noop, n_compared);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/bst_pkg.sv
rtl/bst_front.sv
rtl/bst_queue.sv
rtl/bst_back.sv
rtl/breakpoint_slot_table.sv
dv/tb.sv
